>>> rtl/dbf_pkg.sv
// ----------------------------------------------------------------------------
// dbf_pkg
// shared types and constants of the discrete belief filter update unit
// ----------------------------------------------------------------------------
package dbf_pkg;

    localparam int NUM_STATES       = 16;
    localparam int NUM_ACTIONS      = 4;
    localparam int NUM_OBSERVATIONS = 8;
    localparam int PROB_FRAC_BITS   = 15;

    localparam int CMD_W   = 3;
    localparam int ACT_W   = 2;
    localparam int OBS_W   = 3;
    localparam int STATE_W = 4;
    localparam int PROB_W  = 16;

    localparam int SUM_W  = 20;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 35;

    localparam logic [PROB_W-1:0] ONE_Q   = 16'd32768;
    localparam logic [PROB_W-1:0] UNIFORM = 16'd2048;

    typedef enum logic [CMD_W-1:0] {
        CMD_UNIFORM  = 3'd0,
        CMD_LOAD_OBS = 3'd1,
        CMD_LOAD_TRN = 3'd2,
        CMD_OBSERVE  = 3'd3,
        CMD_QUERY    = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRD,
        S_WMUL,
        S_WACC,
        S_CHECK,
        S_DSTART,
        S_DWAIT,
        S_MRD,
        S_MMUL,
        S_MACC,
        S_MWR,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

>>> rtl/dbf_in_if.sv
// ----------------------------------------------------------------------------
// dbf_in_if
// input item channel: command and table load fields
// ----------------------------------------------------------------------------
interface dbf_in_if;
    logic                          valid;
    logic                          ready;
    logic [dbf_pkg::CMD_W-1:0]     command;
    logic [dbf_pkg::ACT_W-1:0]     action;
    logic [dbf_pkg::OBS_W-1:0]     observation;
    logic [dbf_pkg::STATE_W-1:0]   state_from;
    logic [dbf_pkg::STATE_W-1:0]   state_to;
    logic [dbf_pkg::PROB_W-1:0]    probability;

    modport source (output valid, command, action, observation, state_from, state_to,
                    probability, input ready);
    modport sink (input valid, command, action, observation, state_from, state_to,
                  probability, output ready);
endinterface

>>> rtl/dbf_out_if.sv
// ----------------------------------------------------------------------------
// dbf_out_if
// result item channel: likelihood and updated belief entries
// ----------------------------------------------------------------------------
interface dbf_out_if;
    logic                          valid;
    logic                          ready;
    logic [dbf_pkg::PROB_W-1:0]    likelihood;
    logic                          zero_evidence;
    logic [dbf_pkg::STATE_W-1:0]   belief_index;
    logic [dbf_pkg::PROB_W-1:0]    belief_value;
    logic                          last;

    modport source (output valid, likelihood, zero_evidence, belief_index, belief_value,
                    last, input ready);
    modport sink (input valid, likelihood, zero_evidence, belief_index, belief_value,
                  last, output ready);
endinterface

>>> rtl/dbf_mul.sv
// ----------------------------------------------------------------------------
// dbf_mul
// shared 16x16 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module dbf_mul (
    input  logic                          clk,
    input  logic [dbf_pkg::PROB_W-1:0]    op_a,
    input  logic [dbf_pkg::PROB_W-1:0]    op_b,
    output logic [dbf_pkg::PROD_W-1:0]    prod
);
    import dbf_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

>>> rtl/dbf_div.sv
// ----------------------------------------------------------------------------
// dbf_div
// bit-serial restoring divider, floor((dividend << 15) / divisor), one bit a cycle
// ----------------------------------------------------------------------------
module dbf_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dbf_pkg::div_ctl_t             ctl_in,
    output dbf_pkg::div_ctl_t             ctl_out,
    input  logic [dbf_pkg::PROB_W-1:0]    dividend,
    input  logic [dbf_pkg::SUM_W-1:0]     divisor,
    output logic [dbf_pkg::PROB_W-1:0]    quotient
);
    import dbf_pkg::*;

    logic [SUM_W-1:0]   rem_reg;
    logic [PROB_W-1:0]  q_reg;
    logic [3:0]         cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [SUM_W:0]     trial;
    logic               ge;

    always_comb
    begin
        trial = (cnt_reg == 4'd0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge    = trial >= {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            rem_reg <= SUM_W'(dividend);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? SUM_W'(trial - {1'b0, divisor}) : SUM_W'(trial);
            q_reg   <= {q_reg[PROB_W-2:0], ge};
        end
    end

    assign ctl_out.start = busy_reg;
    assign ctl_out.done  = done_reg;
    assign quotient      = q_reg;

endmodule

>>> rtl/discrete_belief_filter_update_unit.sv
// ----------------------------------------------------------------------------
// discrete_belief_filter_update_unit
// fixed-point bayes filter over 16 hidden states with table loads
// ----------------------------------------------------------------------------
// Loads and uniform reset are written as the item is accepted. A query reads
// the observation memory, multiplies and accumulates for each state. An observe
// runs the same weighing pass, then, unless the evidence sum is zero, the
// bit-serial divider once per state, then reads, multiplies and accumulates
// each transition term (256 terms) through the single shared multiplier, with
// one result item per state as each new belief entry is finished. The input is
// not ready while an item is in work; the last result may still wait while the
// next item is taken.
module discrete_belief_filter_update_unit (
    input  logic      clk,
    input  logic      rst_n,
    dbf_in_if.sink    in_ch,
    dbf_out_if.source out_ch
);
    import dbf_pkg::*;

    localparam int OBS_DEPTH = NUM_STATES * NUM_ACTIONS * NUM_OBSERVATIONS;
    localparam int TRN_DEPTH = NUM_STATES * NUM_ACTIONS * NUM_STATES;
    localparam int OBS_AW    = $clog2(OBS_DEPTH);
    localparam int TRN_AW    = $clog2(TRN_DEPTH);

    state_t             state_reg, state_next;
    logic               is_query_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [OBS_W-1:0]   obs_reg;
    logic [STATE_W-1:0] s_reg;
    logic [STATE_W-1:0] s2_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [ACC_W-1:0]   acc_reg;

    logic [PROB_W-1:0]  belief_reg  [NUM_STATES];
    logic [PROB_W-1:0]  scratch_reg [NUM_STATES];
    logic [PROB_W-1:0]  norm_reg    [NUM_STATES];

    logic [PROB_W-1:0]  obs_mem [OBS_DEPTH];
    logic [PROB_W-1:0]  trn_mem [TRN_DEPTH];
    logic [PROB_W-1:0]  obs_rd_reg;
    logic [PROB_W-1:0]  trn_rd_reg;

    logic               out_valid_reg;
    logic [PROB_W-1:0]  lik_reg;
    logic               zero_reg;
    logic [STATE_W-1:0] idx_reg;
    logic [PROB_W-1:0]  val_reg;
    logic               last_reg;

    logic               accept;
    logic               out_free;
    logic               emit_load;
    logic [PROB_W-1:0]  prob_sat;
    logic [PROB_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0]  prod;
    div_ctl_t           div_in, div_out;
    logic [PROB_W-1:0]  quotient;
    logic [PROB_W-1:0]  sum_sat;
    logic [SUM_W-1:0]   mix_shift;
    logic [PROB_W-1:0]  mix_sat;
    logic               full_update;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign emit_load   = (state_reg == S_EMIT) && out_free;
    assign prob_sat    = (in_ch.probability > ONE_Q) ? ONE_Q : in_ch.probability;
    assign sum_sat     = (sum_reg > SUM_W'(ONE_Q)) ? ONE_Q : sum_reg[PROB_W-1:0];
    assign mix_shift   = acc_reg[ACC_W-1:PROB_FRAC_BITS];
    assign mix_sat     = (mix_shift > SUM_W'(ONE_Q)) ? ONE_Q : mix_shift[PROB_W-1:0];
    assign full_update = !is_query_reg && (sum_reg != '0);

    assign mul_a = (state_reg == S_WMUL) ? belief_reg[s_reg] : norm_reg[s_reg];
    assign mul_b = (state_reg == S_WMUL) ? obs_rd_reg : trn_rd_reg;

    assign div_in.start = (state_reg == S_DSTART);
    assign div_in.done  = 1'b0;

    dbf_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    dbf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_in),
        .ctl_out  (div_out),
        .dividend (scratch_reg[s_reg]),
        .divisor  (sum_reg),
        .quotient (quotient)
    );

    // table memories
    always_ff @(posedge clk)
    begin
        if (accept && cmd_t'(in_ch.command) == CMD_LOAD_OBS)
        begin
            obs_mem[{in_ch.state_from, in_ch.action, in_ch.observation}] <= prob_sat;
        end
        if (state_reg == S_WRD)
        begin
            obs_rd_reg <= obs_mem[OBS_AW'({s_reg, act_reg, obs_reg})];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd_t'(in_ch.command) == CMD_LOAD_TRN)
        begin
            trn_mem[{in_ch.state_from, in_ch.action, in_ch.state_to}] <= prob_sat;
        end
        if (state_reg == S_MRD)
        begin
            trn_rd_reg <= trn_mem[TRN_AW'({s_reg, act_reg, s2_reg})];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd_t'(in_ch.command) == CMD_OBSERVE ||
                               cmd_t'(in_ch.command) == CMD_QUERY))
                begin
                    state_next = S_WRD;
                end
            end
            S_WRD:    state_next = S_WMUL;
            S_WMUL:   state_next = S_WACC;
            S_WACC:   state_next = (s_reg == STATE_W'(NUM_STATES - 1)) ? S_CHECK : S_WRD;
            S_CHECK:  state_next = full_update ? S_DSTART : S_EMIT;
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT:
            begin
                if (div_out.done)
                begin
                    state_next = (s_reg == STATE_W'(NUM_STATES - 1)) ? S_MRD : S_DSTART;
                end
            end
            S_MRD:    state_next = S_MMUL;
            S_MMUL:   state_next = S_MACC;
            S_MACC:   state_next = (s_reg == STATE_W'(NUM_STATES - 1)) ? S_MWR : S_MRD;
            S_MWR:    state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (full_update && s2_reg != STATE_W'(NUM_STATES - 1))
                    begin
                        state_next = S_MRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // belief store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                belief_reg[i] <= UNIFORM;
            end
        end
        else if (accept && cmd_t'(in_ch.command) == CMD_UNIFORM)
        begin
            for (int i = 0; i < NUM_STATES; i++)
            begin
                belief_reg[i] <= UNIFORM;
            end
        end
        else if (state_reg == S_MWR)
        begin
            belief_reg[s2_reg] <= mix_sat;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    is_query_reg <= (cmd_t'(in_ch.command) == CMD_QUERY);
                    act_reg      <= in_ch.action;
                    obs_reg      <= in_ch.observation;
                    s_reg        <= '0;
                    sum_reg      <= '0;
                end
            end
            S_WACC:
            begin
                scratch_reg[s_reg] <= prod[PROB_FRAC_BITS + PROB_W - 1:PROB_FRAC_BITS];
                sum_reg <= sum_reg + SUM_W'(prod[PROB_FRAC_BITS + PROB_W - 1:PROB_FRAC_BITS]);
                s_reg   <= s_reg + STATE_W'(1);
            end
            S_CHECK:
            begin
                s_reg  <= '0;
                s2_reg <= '0;
            end
            S_DWAIT:
            begin
                if (div_out.done)
                begin
                    norm_reg[s_reg] <= quotient;
                    s_reg           <= s_reg + STATE_W'(1);
                    acc_reg         <= '0;
                end
            end
            S_MACC:
            begin
                acc_reg <= acc_reg + ACC_W'(prod);
                s_reg   <= s_reg + STATE_W'(1);
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    s2_reg  <= s2_reg + STATE_W'(1);
                    acc_reg <= '0;
                end
            end
            S_WRD, S_WMUL, S_DSTART, S_MRD, S_MMUL, S_MWR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            lik_reg  <= sum_sat;
            zero_reg <= (sum_reg == '0);
            idx_reg  <= full_update ? s2_reg : '0;
            val_reg  <= full_update ? belief_reg[s2_reg] : '0;
            last_reg <= !full_update || (s2_reg == STATE_W'(NUM_STATES - 1));
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.likelihood    = lik_reg;
    assign out_ch.zero_evidence = zero_reg;
    assign out_ch.belief_index  = idx_reg;
    assign out_ch.belief_value  = val_reg;
    assign out_ch.last          = last_reg;

    a_zero_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.zero_evidence |-> out_ch.last && out_ch.belief_value == '0)
        else $error("zero evidence result is not a lone empty item");

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_out.done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait state");

    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last |-> state_reg != S_IDLE)
        else $error("non-final result while sequencer idle");

endmodule
